FILE: rtl/ackodo_pkg.sv
// Shared types, constants and arithmetic helpers for the odometry integrator.
package ackodo_pkg;

	// Sequencer states: idle, one per serial unit pass, and done.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ANG,
		ST_COR_YAW,
		ST_MUL_NUM,
		ST_MUL_DEN,
		ST_DIV_YAW,
		ST_MUL_UA,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_COR_HDG,
		ST_MUL_X1,
		ST_MUL_X2,
		ST_MUL_Y1,
		ST_MUL_Y2,
		ST_COR_QUAT,
		ST_DONE
	} state_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_WHEELBASE = 2'd0,
		REG_PWM_LOW   = 2'd1,
		REG_PWM_HIGH  = 2'd2
	} reg_idx_t;

	localparam logic [10:0] WHEELBASE_RST = 11'd324;
	localparam logic [15:0] PWM_LOW_RST   = 16'd6554;
	localparam logic [15:0] PWM_HIGH_RST  = 16'd13108;

	// Quarter and half turn of a binary angle, in the 34-bit CORDIC angle format.
	localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;
	localparam logic signed [33:0] HALF_TURN    = 34'sd2147483648;
	localparam logic [31:0]        ANGLE_ZERO   = 32'h4000_0000;

	// CORDIC start value that cancels the rotation gain, Q2.30.
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	// 2^32 / (2 pi), turns rad/s times seconds into binary angle units.
	localparam logic [29:0] INV_TWO_PI = 30'd683565276;

	localparam logic signed [31:0] YAW_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] YAW_MIN = 32'sh8000_0000;

	// Arctangent of 2^-i as a binary angle.
	function automatic logic [29:0] atan_val(input logic [4:0] i);
		logic [29:0] v;
		unique case (i)
			5'd0:  v = 30'd536870912;
			5'd1:  v = 30'd316933406;
			5'd2:  v = 30'd167458907;
			5'd3:  v = 30'd85004756;
			5'd4:  v = 30'd42667331;
			5'd5:  v = 30'd21354465;
			5'd6:  v = 30'd10679838;
			5'd7:  v = 30'd5340245;
			5'd8:  v = 30'd2670163;
			5'd9:  v = 30'd1335087;
			5'd10: v = 30'd667544;
			5'd11: v = 30'd333772;
			5'd12: v = 30'd166886;
			5'd13: v = 30'd83443;
			5'd14: v = 30'd41722;
			5'd15: v = 30'd20861;
			5'd16: v = 30'd10430;
			5'd17: v = 30'd5215;
			5'd18: v = 30'd2608;
			5'd19: v = 30'd1304;
			5'd20: v = 30'd652;
			5'd21: v = 30'd326;
			5'd22: v = 30'd163;
			5'd23: v = 30'd81;
			5'd24: v = 30'd41;
			5'd25: v = 30'd20;
			5'd26: v = 30'd10;
			5'd27: v = 30'd5;
			5'd28: v = 30'd3;
			5'd29: v = 30'd1;
			5'd30: v = 30'd1;
			5'd31: v = 30'd0;
		endcase
		return v;
	endfunction

	// Round a Q2.30 value to Q1.15 and saturate.
	function automatic logic signed [15:0] q30_to_q15(input logic signed [33:0] v);
		logic signed [34:0] r;
		logic signed [15:0] o;
		r = (35'(v) + 35'sd16384) >>> 15;
		if (r > 35'sd32767) begin
			o = 16'sh7FFF;
		end else if (r < -35'sd32768) begin
			o = 16'sh8000;
		end else begin
			o = r[15:0];
		end
		return o;
	endfunction

	// Magnitude of a CORDIC result, which always stays below 2^31.
	function automatic logic [31:0] mag32(input logic signed [33:0] v);
		logic signed [33:0] a;
		a = v[33] ? -v : v;
		return a[31:0];
	endfunction

endpackage

FILE: rtl/ackermann_odometry_integrator_core.sv
// Ackermann dead-reckoning integrator: serial multiplier, divider and CORDIC sequencer.
//
// Usage: one input item (speed, steer_pwm, delta_t) per odometry tick gives one result
// item (pos_x, pos_y, heading, yaw_rate, quat_z, quat_w). Both channels use valid/stall;
// an item moves on a rising edge with valid high and stall low. The configuration
// channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes wheelbase_mm, pwm_low and
// pwm_high; cfg_ready is always high and writes are meant for idle periods.
// Sequencing: one item runs through two restoring divisions, three CORDIC passes
// of CORDIC_STEPS rotations each and nine shift-add multiplies that retire one multiplier
// bit per cycle and end when no set bits remain, all on the single shared multiplier,
// divider and CORDIC; a new item is taken only when the previous one is done
// computing, while its result may still wait in the output register.
// The output register holds a finished item while out_stall is high; the next item
// may be accepted and computed meanwhile and waits at the end until the register frees.
// Reset clears the position and heading accumulators and loads the default
// configuration.
module ackermann_odometry_integrator_core #(
	parameter int CORDIC_STEPS  = 16,
	parameter int POS_FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] speed,
	input  logic [15:0]        steer_pwm,
	input  logic [15:0]        delta_t,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic [31:0]        heading,
	output logic signed [31:0] yaw_rate,
	output logic signed [15:0] quat_z,
	output logic signed [15:0] quat_w,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	localparam int CW = $clog2(CORDIC_STEPS + 1);
	localparam int SH = 46 - POS_FRAC_BITS;

	ackodo_pkg::state_t state_q, state_d;

	// Configuration and accumulators.
	logic [10:0]        wheelbase_q;
	logic [15:0]        pwm_low_q, pwm_high_q;
	logic signed [31:0] acc_x_q, acc_y_q;
	logic [31:0]        acc_heading_q;
	logic               out_valid_q;

	// Item operands and intermediate results.
	logic signed [15:0] spd_q;
	logic [15:0]        dt_q;
	logic               eq_q;
	logic [31:0]        cmag_q, hsmag_q;
	logic               neg_q, numzero_q, ovf_q, hs_neg_q, pneg_q, yr_neg_q;
	logic [55:0]        un_q;
	logic [30:0]        ua_hi_q;
	logic signed [31:0] yr_q;
	logic signed [15:0] qz_q, qw_q;

	// Serial multiplier.
	logic [63:0] mul_acc_q, mul_cand_q;
	logic [31:0] mul_plier_q;
	logic        mul_done;

	// Serial divider.
	logic [47:0] div_rem_q, div_den_q;
	logic [31:0] div_low_q, div_quo_q;
	logic [5:0]  div_cnt_q;
	logic [48:0] div_r2;
	logic        div_ge;
	logic [47:0] div_rem_next;
	logic        div_done;

	// Iterative CORDIC.
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic [CW-1:0]      ci_q;
	logic               cflip_q;
	logic signed [33:0] cor_dx, cor_dy, cor_at, cos_res, sin_res;
	logic               cor_done;
	logic [31:0]        cor_src;
	logic signed [33:0] cor_a, cor_a0;
	logic               cor_flip;

	// Output registers.
	logic signed [31:0] pos_x_q, pos_y_q, yaw_rate_q;
	logic [31:0]        heading_q;
	logic signed [15:0] quat_z_q, quat_w_q;

	// Combinational helpers.
	logic [15:0]        spd_mag;
	logic               spd_neg;
	logic [25:0]        spk;
	logic [15:0]        pwm_lo, pwm_hi, pwm_c, pwm_m, pwm_d;
	logic [31:0]        steer_ang;
	logic signed [31:0] yr_calc;
	logic [31:0]        yr_abs;
	logic [31:0]        hdg_new;
	logic signed [63:0] pos_v, pos_step, pos_sum;
	logic signed [31:0] pos_base, pos_sat;
	logic [10:0]        wb_eff;
	logic               in_acc;

	assign in_stall  = (state_q != ackodo_pkg::ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	assign out_valid = out_valid_q;
	assign pos_x     = pos_x_q;
	assign pos_y     = pos_y_q;
	assign heading   = heading_q;
	assign yaw_rate  = yaw_rate_q;
	assign quat_z    = quat_z_q;
	assign quat_w    = quat_w_q;

	// Speed magnitude and speed times one thousand (1024 - 16 - 8).
	assign spd_neg = spd_q[15];
	assign spd_mag = spd_q[15] ? (~spd_q + 16'd1) : spd_q;
	assign spk     = ({10'd0, spd_mag} << 10) - ({10'd0, spd_mag} << 4)
		- ({10'd0, spd_mag} << 3);
	assign wb_eff  = (wheelbase_q == 11'd0) ? 11'd1 : wheelbase_q;

	// Clamp the incoming PWM and form the numerator and divisor of the steering map.
	always_comb begin
		pwm_lo = (pwm_low_q < pwm_high_q) ? pwm_low_q : pwm_high_q;
		pwm_hi = (pwm_low_q < pwm_high_q) ? pwm_high_q : pwm_low_q;
		if (steer_pwm < pwm_lo) begin
			pwm_c = pwm_lo;
		end else if (steer_pwm > pwm_hi) begin
			pwm_c = pwm_hi;
		end else begin
			pwm_c = steer_pwm;
		end
		pwm_m = (pwm_c >= pwm_low_q) ? (pwm_c - pwm_low_q) : (pwm_low_q - pwm_c);
		pwm_d = (pwm_high_q >= pwm_low_q) ? (pwm_high_q - pwm_low_q)
			: (pwm_low_q - pwm_high_q);
	end

	// One restoring division step per cycle.
	assign div_r2       = {div_rem_q, div_low_q[31]};
	assign div_ge       = div_r2 >= {1'b0, div_den_q};
	assign div_rem_next = div_ge ? 48'(div_r2 - {1'b0, div_den_q}) : div_r2[47:0];
	assign div_done     = (div_cnt_q == 6'd32);

	assign mul_done = (mul_plier_q == 32'd0);

	// One CORDIC rotation per cycle.
	assign cor_dx   = cy_q >>> ci_q;
	assign cor_dy   = cx_q >>> ci_q;
	assign cor_at   = $signed({4'd0, ackodo_pkg::atan_val(5'(ci_q))});
	assign cor_done = (ci_q == CW'(CORDIC_STEPS));
	assign cos_res  = cflip_q ? -cx_q : cx_q;
	assign sin_res  = cflip_q ? -cy_q : cy_q;

	// Steering angle, yaw rate and new heading from the finished unit results.
	always_comb begin
		steer_ang = eq_q ? 32'd0 : (ackodo_pkg::ANGLE_ZERO - div_quo_q);
		if (numzero_q) begin
			yr_calc = 32'sd0;
		end else if (ovf_q || div_quo_q[31]) begin
			yr_calc = neg_q ? ackodo_pkg::YAW_MIN : ackodo_pkg::YAW_MAX;
		end else begin
			yr_calc = neg_q ? -$signed(div_quo_q) : $signed(div_quo_q);
		end
		yr_abs  = yr_calc[31] ? (~yr_calc + 32'd1) : yr_calc;
		hdg_new = yr_neg_q ? (acc_heading_q - mul_acc_q[47:16])
			: (acc_heading_q + mul_acc_q[47:16]);
	end

	// Source angle of the next CORDIC pass, folded into the right half plane.
	always_comb begin
		priority case (state_q)
			ackodo_pkg::ST_ANG:    cor_src = steer_ang;
			ackodo_pkg::ST_MUL_HI: cor_src = hdg_new;
			default:               cor_src = {1'b0, acc_heading_q[31:1]};
		endcase
		cor_a0   = $signed({{2{cor_src[31]}}, cor_src});
		cor_flip = 1'b0;
		if (cor_a0 > ackodo_pkg::QUARTER_TURN) begin
			cor_a    = cor_a0 - ackodo_pkg::HALF_TURN;
			cor_flip = 1'b1;
		end else if (cor_a0 < -ackodo_pkg::QUARTER_TURN) begin
			cor_a    = cor_a0 + ackodo_pkg::HALF_TURN;
			cor_flip = 1'b1;
		end else begin
			cor_a = cor_a0;
		end
	end

	// Position step with floor shift, added to x or y with saturation.
	always_comb begin
		pos_v    = pneg_q ? -$signed(mul_acc_q) : $signed(mul_acc_q);
		pos_step = pos_v >>> SH;
		pos_base = (state_q == ackodo_pkg::ST_MUL_X2) ? acc_x_q : acc_y_q;
		pos_sum  = 64'(pos_base) + pos_step;
		if (pos_sum > 64'sh7FFF_FFFF) begin
			pos_sat = ackodo_pkg::YAW_MAX;
		end else if (pos_sum < -64'sh8000_0000) begin
			pos_sat = ackodo_pkg::YAW_MIN;
		end else begin
			pos_sat = pos_sum[31:0];
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ackodo_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state: each pass ends when its unit reports done.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ackodo_pkg::ST_IDLE:     if (in_acc) state_d = ackodo_pkg::ST_ANG;
			ackodo_pkg::ST_ANG:      if (div_done) state_d = ackodo_pkg::ST_COR_YAW;
			ackodo_pkg::ST_COR_YAW:  if (cor_done) state_d = ackodo_pkg::ST_MUL_NUM;
			ackodo_pkg::ST_MUL_NUM:  if (mul_done) state_d = ackodo_pkg::ST_MUL_DEN;
			ackodo_pkg::ST_MUL_DEN:  if (mul_done) state_d = ackodo_pkg::ST_DIV_YAW;
			ackodo_pkg::ST_DIV_YAW:  if (div_done) state_d = ackodo_pkg::ST_MUL_UA;
			ackodo_pkg::ST_MUL_UA:   if (mul_done) state_d = ackodo_pkg::ST_MUL_LO;
			ackodo_pkg::ST_MUL_LO:   if (mul_done) state_d = ackodo_pkg::ST_MUL_HI;
			ackodo_pkg::ST_MUL_HI:   if (mul_done) state_d = ackodo_pkg::ST_COR_HDG;
			ackodo_pkg::ST_COR_HDG:  if (cor_done) state_d = ackodo_pkg::ST_MUL_X1;
			ackodo_pkg::ST_MUL_X1:   if (mul_done) state_d = ackodo_pkg::ST_MUL_X2;
			ackodo_pkg::ST_MUL_X2:   if (mul_done) state_d = ackodo_pkg::ST_MUL_Y1;
			ackodo_pkg::ST_MUL_Y1:   if (mul_done) state_d = ackodo_pkg::ST_MUL_Y2;
			ackodo_pkg::ST_MUL_Y2:   if (mul_done) state_d = ackodo_pkg::ST_COR_QUAT;
			ackodo_pkg::ST_COR_QUAT: if (cor_done) state_d = ackodo_pkg::ST_DONE;
			ackodo_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) state_d = ackodo_pkg::ST_IDLE;
			end
		endcase
	end

	// Configuration, accumulators and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheelbase_q   <= ackodo_pkg::WHEELBASE_RST;
			pwm_low_q     <= ackodo_pkg::PWM_LOW_RST;
			pwm_high_q    <= ackodo_pkg::PWM_HIGH_RST;
			acc_x_q       <= 32'sd0;
			acc_y_q       <= 32'sd0;
			acc_heading_q <= 32'd0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == ackodo_pkg::REG_WHEELBASE) wheelbase_q <= cfg_data[10:0];
				if (cfg_index == ackodo_pkg::REG_PWM_LOW) pwm_low_q <= cfg_data;
				if (cfg_index == ackodo_pkg::REG_PWM_HIGH) pwm_high_q <= cfg_data;
			end
			if (state_q == ackodo_pkg::ST_MUL_HI && mul_done) acc_heading_q <= hdg_new;
			if (state_q == ackodo_pkg::ST_MUL_X2 && mul_done) acc_x_q <= pos_sat;
			if (state_q == ackodo_pkg::ST_MUL_Y2 && mul_done) acc_y_q <= pos_sat;
			if (state_q == ackodo_pkg::ST_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath: step the active unit, or load the next one when it is done.
	always_ff @(posedge clk) begin
		if (!cor_done) begin
			if (cz_q >= 34'sd0) begin
				cx_q <= cx_q - cor_dx;
				cy_q <= cy_q + cor_dy;
				cz_q <= cz_q - cor_at;
			end else begin
				cx_q <= cx_q + cor_dx;
				cy_q <= cy_q - cor_dy;
				cz_q <= cz_q + cor_at;
			end
			ci_q <= ci_q + CW'(1);
		end
		if (!mul_done) begin
			mul_acc_q   <= mul_acc_q + (mul_plier_q[0] ? mul_cand_q : 64'd0);
			mul_cand_q  <= mul_cand_q << 1;
			mul_plier_q <= mul_plier_q >> 1;
		end
		if (!div_done) begin
			div_rem_q <= div_rem_next;
			div_low_q <= div_low_q << 1;
			div_quo_q <= {div_quo_q[30:0], div_ge};
			div_cnt_q <= div_cnt_q + 6'd1;
		end

		unique case (state_q)
			ackodo_pkg::ST_IDLE: begin
				if (in_acc) begin
					spd_q     <= speed;
					dt_q      <= delta_t;
					eq_q      <= (pwm_low_q == pwm_high_q);
					div_rem_q <= {33'd0, pwm_m[15:1]};
					div_low_q <= {pwm_m[0], 31'd0};
					div_den_q <= {32'd0, pwm_d};
					div_quo_q <= 32'd0;
					div_cnt_q <= 6'd0;
				end
			end
			ackodo_pkg::ST_ANG, ackodo_pkg::ST_MUL_HI, ackodo_pkg::ST_MUL_Y2: begin
				if ((state_q == ackodo_pkg::ST_ANG && div_done) ||
						(state_q != ackodo_pkg::ST_ANG && mul_done)) begin
					cx_q    <= ackodo_pkg::CORDIC_GAIN;
					cy_q    <= 34'sd0;
					cz_q    <= cor_a;
					cflip_q <= cor_flip;
					ci_q    <= '0;
				end
			end
			ackodo_pkg::ST_COR_YAW: begin
				if (cor_done) begin
					cmag_q      <= ackodo_pkg::mag32(cos_res);
					neg_q       <= spd_neg ^ sin_res[33] ^ cos_res[33];
					numzero_q   <= (spd_q == 16'sd0) || (sin_res == 34'sd0);
					mul_acc_q   <= 64'd0;
					mul_cand_q  <= {32'd0, ackodo_pkg::mag32(sin_res)};
					mul_plier_q <= {6'd0, spk};
				end
			end
			ackodo_pkg::ST_MUL_NUM: begin
				if (mul_done) begin
					un_q        <= mul_acc_q[55:0];
					mul_acc_q   <= 64'd0;
					mul_cand_q  <= {32'd0, cmag_q};
					mul_plier_q <= {21'd0, wb_eff};
				end
			end
			ackodo_pkg::ST_MUL_DEN: begin
				if (mul_done) begin
					ovf_q     <= {8'd0, un_q[55:16]} >= mul_acc_q[47:0];
					div_rem_q <= {8'd0, un_q[55:16]};
					div_low_q <= {un_q[15:0], 16'd0};
					div_den_q <= mul_acc_q[47:0];
					div_quo_q <= 32'd0;
					div_cnt_q <= 6'd0;
				end
			end
			ackodo_pkg::ST_DIV_YAW: begin
				if (div_done) begin
					yr_q        <= yr_calc;
					yr_neg_q    <= yr_calc[31];
					mul_acc_q   <= 64'd0;
					mul_cand_q  <= {32'd0, yr_abs};
					mul_plier_q <= {16'd0, dt_q};
				end
			end
			ackodo_pkg::ST_MUL_UA: begin
				if (mul_done) begin
					ua_hi_q     <= mul_acc_q[46:16];
					mul_acc_q   <= 64'd0;
					mul_cand_q  <= {34'd0, ackodo_pkg::INV_TWO_PI};
					mul_plier_q <= {16'd0, mul_acc_q[15:0]};
				end
			end
			ackodo_pkg::ST_MUL_LO: begin
				if (mul_done) begin
					mul_acc_q   <= mul_acc_q >> 16;
					mul_cand_q  <= {34'd0, ackodo_pkg::INV_TWO_PI};
					mul_plier_q <= {1'b0, ua_hi_q};
				end
			end
			ackodo_pkg::ST_COR_HDG: begin
				if (cor_done) begin
					hsmag_q     <= ackodo_pkg::mag32(sin_res);
					hs_neg_q    <= sin_res[33];
					pneg_q      <= spd_neg ^ cos_res[33];
					mul_acc_q   <= 64'd0;
					mul_cand_q  <= {32'd0, ackodo_pkg::mag32(cos_res)};
					mul_plier_q <= {16'd0, spd_mag};
				end
			end
			ackodo_pkg::ST_MUL_X1, ackodo_pkg::ST_MUL_Y1: begin
				if (mul_done) begin
					mul_acc_q   <= 64'd0;
					mul_cand_q  <= mul_acc_q;
					mul_plier_q <= {16'd0, dt_q};
				end
			end
			ackodo_pkg::ST_MUL_X2: begin
				if (mul_done) begin
					pneg_q      <= spd_neg ^ hs_neg_q;
					mul_acc_q   <= 64'd0;
					mul_cand_q  <= {32'd0, hsmag_q};
					mul_plier_q <= {16'd0, spd_mag};
				end
			end
			ackodo_pkg::ST_COR_QUAT: begin
				if (cor_done) begin
					qz_q <= ackodo_pkg::q30_to_q15(sin_res);
					qw_q <= ackodo_pkg::q30_to_q15(cos_res);
				end
			end
			ackodo_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					pos_x_q    <= acc_x_q;
					pos_y_q    <= acc_y_q;
					heading_q  <= acc_heading_q;
					yaw_rate_q <= yr_q;
					quat_z_q   <= qz_q;
					quat_w_q   <= qw_q;
				end
			end
		endcase
	end

	// The output register is only loaded from the final state.
	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ackodo_pkg::ST_DONE))
		else $error("result item raised outside the final state");

	// An accepted item always starts the steering division.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ackodo_pkg::ST_ANG))
		else $error("accepted item did not start the sequence");

	// The divider never runs past its quotient width.
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ackodo_pkg::ST_ANG || state_q == ackodo_pkg::ST_DIV_YAW)
			|-> (div_cnt_q <= 6'd32))
		else $error("divider step count overran");

	// The CORDIC counter stays within the configured number of rotations.
	a_cordic_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ackodo_pkg::ST_COR_YAW || state_q == ackodo_pkg::ST_COR_HDG ||
			state_q == ackodo_pkg::ST_COR_QUAT) |-> (ci_q <= CW'(CORDIC_STEPS)))
		else $error("CORDIC step count overran");

	// A held result is never overwritten while the receiver stalls.
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ackodo_pkg::ST_DONE && out_valid_q && out_stall)
			|=> (state_q == ackodo_pkg::ST_DONE))
		else $error("sequence left the final state while the result was held");

endmodule
